// File: design/pba_pkg.sv
// ----------------------------------------------------------------------------
// Paged bitmap ID allocator package
// Shared sizes, codes, the store command bundle and the bit-search helpers
// used by the allocator sequencer, its page store and its find-first unit.
// ----------------------------------------------------------------------------
package pba_pkg;

   // Page geometry and ID space.
   localparam int SLOTS_PER_PAGE = 64;
   localparam int ID_LIMIT       = 65535;
   localparam int PAGE_COUNT     = 1024;

   localparam int ID_W   = 16;
   localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);
   localparam int PAGE_W = ID_W - SLOT_W;
   localparam int PC_W   = PAGE_W + 1;

   // The per-page free summary is kept as rows of pages.
   localparam int ROW_PAGES = 32;
   localparam int ROW_SEL_W = $clog2(ROW_PAGES);
   localparam int ROW_IDX_W = PAGE_W - ROW_SEL_W;
   localparam int ROW_COUNT = PAGE_COUNT / ROW_PAGES;

   // Pages that may ever be created, and the shape of the last partial page.
   localparam int ID_PAGES     = (ID_LIMIT + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
   localparam int CREATE_LIMIT = (PAGE_COUNT < ID_PAGES) ? PAGE_COUNT : ID_PAGES;
   localparam int FULL_PAGES   = ID_LIMIT / SLOTS_PER_PAGE;
   localparam int TAIL_SLOTS   = ID_LIMIT % SLOTS_PER_PAGE;

   localparam logic [ID_W-1:0]           INVALID_ID = '1;
   localparam logic [SLOTS_PER_PAGE-1:0] ONE_SLOT   = SLOTS_PER_PAGE'(1);
   localparam logic [ROW_PAGES-1:0]      ONE_ROW    = ROW_PAGES'(1);

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_OCCUPY  = 2'd1,
      OP_RELEASE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_INVALID  = 2'd2,
      STATUS_BANNED   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC_ROW,
      ST_ALLOC_PAGE_SCAN,
      ST_ALLOC_BM_READ,
      ST_ALLOC_SLOT_SCAN,
      ST_ALLOC_WRITE,
      ST_CREATE_READ,
      ST_CREATE_WRITE,
      ST_CHECK_READ,
      ST_CHECK_UPDATE,
      ST_DONE
   } state_type;

   // Read and write requests presented to the page store.
   typedef struct packed {
      logic                      bm_rd;
      logic                      bm_wr;
      logic [PAGE_W-1:0]         bm_addr;
      logic [SLOTS_PER_PAGE-1:0] bm_wdata;
      logic                      sum_rd;
      logic                      sum_wr;
      logic [ROW_IDX_W-1:0]      sum_addr;
      logic [ROW_PAGES-1:0]      sum_wdata;
   } store_cmd_type;

   // Index of the lowest set bit; isolate it, then encode the one-hot word.
   function automatic logic [SLOT_W-1:0] lowest_index(input logic [SLOTS_PER_PAGE-1:0] word);
      logic [SLOTS_PER_PAGE-1:0] isolated;
      logic [SLOT_W-1:0]         index;
      isolated = word & (~word + ONE_SLOT);
      index    = '0;
      for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
         if (isolated[i]) begin
            index = index | SLOT_W'(i);
         end
      end
      return index;
   endfunction

   // Free bitmap of a freshly created page: only slots below the ID limit are free.
   function automatic logic [SLOTS_PER_PAGE-1:0] page_free_mask(input logic [PAGE_W-1:0] page);
      logic [SLOTS_PER_PAGE-1:0] mask;
      if ({1'b0, page} < PC_W'(FULL_PAGES)) begin
         mask = '1;
      end else if ({1'b0, page} == PC_W'(FULL_PAGES)) begin
         mask = {SLOTS_PER_PAGE{1'b1}} >> (SLOTS_PER_PAGE - TAIL_SLOTS);
      end else begin
         mask = '0;
      end
      return mask;
   endfunction

endpackage

// File: design/pba_scan.sv
// ----------------------------------------------------------------------------
// Find-first unit
// Shared lowest-set-bit search with a registered result. The sequencer runs
// it over the row summary, over one summary row and over one page bitmap.
// ----------------------------------------------------------------------------
module pba_scan
   import pba_pkg::*;
(
   input  logic                      clock,
   input  logic [SLOTS_PER_PAGE-1:0] scan_word,
   output logic [SLOT_W-1:0]         scan_index,
   output logic                      scan_found
);

   logic [SLOT_W-1:0] index_ff;
   logic [SLOT_W-1:0] index_in;
   logic              found_ff;
   logic              found_in;

   // Search the presented word.
   assign index_in = lowest_index(scan_word);
   assign found_in = |scan_word;

   // The result is registered and valid in the following cycle.
   always_ff @(posedge clock) begin
      index_ff <= index_in;
      found_ff <= found_in;
   end

   assign scan_index = index_ff;
   assign scan_found = found_ff;

endmodule

// File: design/pba_store.sv
// ----------------------------------------------------------------------------
// Page store
// Single-port memories for the page free bitmaps and the page free summary
// rows, plus one flip-flop per summary row that marks a row with free pages.
// ----------------------------------------------------------------------------
module pba_store
   import pba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  store_cmd_type             cmd,
   output logic [SLOTS_PER_PAGE-1:0] bm_rdata,
   output logic [ROW_PAGES-1:0]      sum_rdata,
   output logic [ROW_COUNT-1:0]      row_nz
);

   logic [SLOTS_PER_PAGE-1:0] bm_mem [PAGE_COUNT];
   logic [ROW_PAGES-1:0]      sum_mem [ROW_COUNT];
   logic [SLOTS_PER_PAGE-1:0] bm_rdata_ff;
   logic [ROW_PAGES-1:0]      sum_rdata_ff;
   logic [ROW_COUNT-1:0]      row_nz_ff;
   logic [ROW_COUNT-1:0]      row_nz_in;

   // Bitmap memory; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (cmd.bm_wr) begin
         bm_mem[cmd.bm_addr] <= cmd.bm_wdata;
      end
      if (cmd.bm_rd) begin
         bm_rdata_ff <= bm_mem[cmd.bm_addr];
      end
   end

   // Summary memory; a row is written whole when its first page is created.
   always_ff @(posedge clock) begin
      if (cmd.sum_wr) begin
         sum_mem[cmd.sum_addr] <= cmd.sum_wdata;
      end
      if (cmd.sum_rd) begin
         sum_rdata_ff <= sum_mem[cmd.sum_addr];
      end
   end

   // Row flags follow every summary row write.
   always_comb begin
      row_nz_in = row_nz_ff;
      if (cmd.sum_wr) begin
         row_nz_in[cmd.sum_addr] = |cmd.sum_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_nz_ff <= '0;
      end else begin
         row_nz_ff <= row_nz_in;
      end
   end

   assign bm_rdata  = bm_rdata_ff;
   assign sum_rdata = sum_rdata_ff;
   assign row_nz    = row_nz_ff;

endmodule

// File: design/paged_bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// Paged bitmap ID allocator
// Lowest-free-first ID allocator over pages of 64 slots created on demand.
//
//   Channel   Direction  Handshake           Word
//   req_      in         req_valid/stall     req_type, req_slot_id
//   rsp_      out        rsp_valid/stall     rsp_status, rsp_granted_id
//
// One request is worked at a time. Release, query and occupy of a created
// page read its bitmap and summary row before any update; rejected arguments
// go straight to the result. Allocate scans the row flags, a summary row and
// a page bitmap when a page has room, else creates a page, or reports no
// space when none can be created. Occupy beyond the last created page first
// creates each page up to the ID's page. Reset clears the page count and the
// summary row flags; the memories need no clearing pass. A stalled result
// waits in the output register while the next request is accepted; the word
// after it waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module paged_bitmap_id_allocator
   import pba_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_type,
   input  logic [ID_W-1:0] req_slot_id,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [ID_W-1:0] rsp_granted_id
);

   state_type                 state_ff;
   state_type                 state_in;
   op_type                    op_ff;
   op_type                    op_in;
   logic [ID_W-1:0]           id_ff;
   logic [ID_W-1:0]           id_in;
   logic [PAGE_W-1:0]         page_ff;
   logic [PAGE_W-1:0]         page_in;
   logic [PC_W-1:0]           pc_ff;
   logic [PC_W-1:0]           pc_in;
   status_type                res_status_ff;
   status_type                res_status_in;
   logic [ID_W-1:0]           res_id_ff;
   logic [ID_W-1:0]           res_id_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [ID_W-1:0]           rsp_id_ff;
   logic [ID_W-1:0]           rsp_id_in;

   store_cmd_type             cmd;
   logic [SLOTS_PER_PAGE-1:0] bm_rdata;
   logic [ROW_PAGES-1:0]      sum_rdata;
   logic [ROW_COUNT-1:0]      row_nz;
   logic [SLOTS_PER_PAGE-1:0] scan_word;
   logic [SLOT_W-1:0]         scan_index;
   logic                      scan_found;

   logic                      req_accept;
   op_type                    req_op;
   logic [PAGE_W-1:0]         req_page;
   logic                      req_out_of_range;
   logic                      req_page_new;
   logic                      rsp_load;

   logic [PAGE_W-1:0]         id_page;
   logic [SLOTS_PER_PAGE-1:0] id_bit;
   logic [ROW_PAGES-1:0]      id_row_bit;
   logic                      id_bit_free;
   logic [SLOTS_PER_PAGE-1:0] occupy_word;
   logic [PAGE_W-1:0]         alloc_page;
   logic [SLOTS_PER_PAGE-1:0] alloc_word;
   logic [ROW_PAGES-1:0]      page_row_bit;
   logic [PAGE_W-1:0]         new_page;
   logic                      create_ok;
   logic [SLOTS_PER_PAGE-1:0] new_mask;
   logic [SLOTS_PER_PAGE-1:0] create_word;
   logic [ROW_PAGES-1:0]      create_row_base;
   logic [ROW_PAGES-1:0]      create_row;

   // Shared find-first unit and page store.
   pba_scan u_scan (
      .clock      (clock),
      .scan_word  (scan_word),
      .scan_index (scan_index),
      .scan_found (scan_found)
   );

   pba_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .bm_rdata  (bm_rdata),
      .sum_rdata (sum_rdata),
      .row_nz    (row_nz)
   );

   // Request decode, taken straight from the input word while idle.
   assign req_stall        = (state_ff != ST_IDLE);
   assign req_accept       = req_valid && !req_stall;
   assign req_op           = op_type'(req_type);
   assign req_page         = req_slot_id[ID_W-1:SLOT_W];
   assign req_out_of_range = ({1'b0, req_slot_id} >= (ID_W + 1)'(ID_LIMIT));
   assign req_page_new     = ({1'b0, req_page} >= pc_ff);

   // Fields of the latched ID.
   assign id_page     = id_ff[ID_W-1:SLOT_W];
   assign id_bit      = ONE_SLOT << id_ff[SLOT_W-1:0];
   assign id_row_bit  = ONE_ROW << id_page[ROW_SEL_W-1:0];
   assign id_bit_free = |(bm_rdata & id_bit);
   assign occupy_word = bm_rdata & ~id_bit;

   // Allocation from an existing page.
   assign alloc_page   = {page_ff[PAGE_W-1:ROW_SEL_W], scan_index[ROW_SEL_W-1:0]};
   assign alloc_word   = bm_rdata & ~(ONE_SLOT << scan_index);
   assign page_row_bit = ONE_ROW << page_ff[ROW_SEL_W-1:0];

   // Page creation; an allocate takes slot zero of the new page at once.
   assign new_page        = pc_ff[PAGE_W-1:0];
   assign create_ok       = (pc_ff < PC_W'(CREATE_LIMIT));
   assign new_mask        = page_free_mask(new_page);
   assign create_word     = (op_ff == OP_ALLOC) ? (new_mask & ~ONE_SLOT) : new_mask;
   assign create_row_base = (new_page[ROW_SEL_W-1:0] == '0) ? '0 : sum_rdata;
   assign create_row      = (|create_word)
                            ? (create_row_base | (ONE_ROW << new_page[ROW_SEL_W-1:0]))
                            : create_row_base;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_ALLOC: begin
                     state_in = ST_ALLOC_ROW;
                  end
                  OP_OCCUPY: begin
                     if (req_out_of_range) begin
                        state_in = ST_DONE;
                     end else if (req_page_new) begin
                        state_in = ST_CREATE_READ;
                     end else begin
                        state_in = ST_CHECK_READ;
                     end
                  end
                  default: begin
                     if (req_out_of_range || req_page_new) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_CHECK_READ;
                     end
                  end
               endcase
            end
         end
         ST_ALLOC_ROW: begin
            state_in = scan_found ? ST_ALLOC_PAGE_SCAN : ST_CREATE_READ;
         end
         ST_ALLOC_PAGE_SCAN: begin
            state_in = ST_ALLOC_BM_READ;
         end
         ST_ALLOC_BM_READ: begin
            state_in = ST_ALLOC_SLOT_SCAN;
         end
         ST_ALLOC_SLOT_SCAN: begin
            state_in = ST_ALLOC_WRITE;
         end
         ST_ALLOC_WRITE: begin
            state_in = ST_DONE;
         end
         ST_CREATE_READ: begin
            state_in = create_ok ? ST_CREATE_WRITE : ST_DONE;
         end
         ST_CREATE_WRITE: begin
            if (op_ff == OP_ALLOC) begin
               state_in = ST_DONE;
            end else if (new_page == id_page) begin
               state_in = ST_CHECK_READ;
            end else begin
               state_in = ST_CREATE_READ;
            end
         end
         ST_CHECK_READ: begin
            state_in = ST_CHECK_UPDATE;
         end
         ST_CHECK_UPDATE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: store requests, scan input and working registers.
   always_comb begin
      cmd           = '0;
      scan_word     = SLOTS_PER_PAGE'(row_nz);
      op_in         = op_ff;
      id_in         = id_ff;
      page_in       = page_ff;
      pc_in         = pc_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_op;
               id_in     = req_slot_id;
               res_id_in = req_slot_id;
               case (req_op)
                  OP_RELEASE: begin
                     res_status_in = req_out_of_range ? STATUS_OK : STATUS_BANNED;
                  end
                  OP_ALLOC: begin
                     res_status_in = STATUS_NO_SPACE;
                  end
                  default: begin
                     res_status_in = req_out_of_range ? STATUS_INVALID : STATUS_BANNED;
                  end
               endcase
            end
         end
         ST_ALLOC_ROW: begin
            cmd.sum_rd   = scan_found;
            cmd.sum_addr = scan_index[ROW_IDX_W-1:0];
            page_in      = {scan_index[ROW_IDX_W-1:0], {ROW_SEL_W{1'b0}}};
         end
         ST_ALLOC_PAGE_SCAN: begin
            scan_word = SLOTS_PER_PAGE'(sum_rdata);
         end
         ST_ALLOC_BM_READ: begin
            page_in     = alloc_page;
            cmd.bm_rd   = 1'b1;
            cmd.bm_addr = alloc_page;
         end
         ST_ALLOC_SLOT_SCAN: begin
            scan_word = bm_rdata;
         end
         ST_ALLOC_WRITE: begin
            cmd.bm_wr     = 1'b1;
            cmd.bm_addr   = page_ff;
            cmd.bm_wdata  = alloc_word;
            cmd.sum_wr    = (alloc_word == '0);
            cmd.sum_addr  = page_ff[PAGE_W-1:ROW_SEL_W];
            cmd.sum_wdata = sum_rdata & ~page_row_bit;
            res_status_in = STATUS_OK;
            res_id_in     = {page_ff, scan_index};
         end
         ST_CREATE_READ: begin
            // Rows are fetched only once their first page exists.
            cmd.sum_rd   = create_ok && (new_page[ROW_SEL_W-1:0] != '0);
            cmd.sum_addr = new_page[PAGE_W-1:ROW_SEL_W];
            if (!create_ok) begin
               res_status_in = STATUS_NO_SPACE;
               res_id_in     = (op_ff == OP_ALLOC) ? INVALID_ID : id_ff;
            end
         end
         ST_CREATE_WRITE: begin
            cmd.bm_wr     = 1'b1;
            cmd.bm_addr   = new_page;
            cmd.bm_wdata  = create_word;
            cmd.sum_wr    = 1'b1;
            cmd.sum_addr  = new_page[PAGE_W-1:ROW_SEL_W];
            cmd.sum_wdata = create_row;
            pc_in         = pc_ff + PC_W'(1);
            if (op_ff == OP_ALLOC) begin
               res_status_in = STATUS_OK;
               res_id_in     = {new_page, {SLOT_W{1'b0}}};
            end
         end
         ST_CHECK_READ: begin
            cmd.bm_rd    = 1'b1;
            cmd.bm_addr  = id_page;
            cmd.sum_rd   = 1'b1;
            cmd.sum_addr = id_page[PAGE_W-1:ROW_SEL_W];
         end
         ST_CHECK_UPDATE: begin
            res_id_in    = id_ff;
            cmd.bm_addr  = id_page;
            cmd.sum_addr = id_page[PAGE_W-1:ROW_SEL_W];
            case (op_ff)
               OP_OCCUPY: begin
                  if (!id_bit_free) begin
                     res_status_in = STATUS_BANNED;
                  end else begin
                     cmd.bm_wr     = 1'b1;
                     cmd.bm_wdata  = occupy_word;
                     cmd.sum_wr    = (occupy_word == '0);
                     cmd.sum_wdata = sum_rdata & ~id_row_bit;
                     res_status_in = STATUS_OK;
                  end
               end
               OP_RELEASE: begin
                  if (id_bit_free) begin
                     res_status_in = STATUS_BANNED;
                  end else begin
                     cmd.bm_wr     = 1'b1;
                     cmd.bm_wdata  = bm_rdata | id_bit;
                     cmd.sum_wr    = 1'b1;
                     cmd.sum_wdata = sum_rdata | id_row_bit;
                     res_status_in = STATUS_OK;
                  end
               end
               default: begin
                  res_status_in = id_bit_free ? STATUS_BANNED : STATUS_OK;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Output register: a finished word moves in once the slot is free.
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
   assign rsp_id_in     = rsp_load ? res_id_ff : rsp_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      page_ff       <= page_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_id_ff;

   // Pages are never removed and never exceed the creation limit.
   a_pages_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (pc_ff >= $past(pc_ff)) && (pc_ff <= PC_W'(CREATE_LIMIT)))
      else $error("page count decreased or passed its limit");

   // A granted ID lies on a created page and below the ID limit.
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (res_status_ff == STATUS_OK) && (op_ff == OP_ALLOC)
      |-> ({1'b0, res_id_ff[ID_W-1:SLOT_W]} < pc_ff)
          && ({1'b0, res_id_ff} < (ID_W + 1)'(ID_LIMIT)))
      else $error("allocate granted an ID outside the created pages");

   // Only requests that create pages can run out of space.
   a_no_space_source: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (res_status_ff == STATUS_NO_SPACE)
      |-> (op_ff == OP_ALLOC) || (op_ff == OP_OCCUPY))
      else $error("no-space status from a request that creates no page");

endmodule
